// ===== design/assert_macros.svh =====
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ===== design/ses_pkg.sv =====
// shared constants, types and helpers of the string escape encoder
package ses_pkg;

  localparam int MAX_LEN = 64;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int CNT_W   = $clog2(MAX_LEN + 1);

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] PRINT_LO  = 8'd32;
  localparam logic [7:0] PRINT_HI  = 8'd127;

  localparam logic [7:0] HEX_DIGITS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };

  typedef enum logic [1:0] {
    KIND_ESC,
    KIND_HEX,
    KIND_EMPTY,
    KIND_LONG
  } kind_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_t;

  // one slot of the read pipeline, from control to the formatter
  typedef struct packed {
    logic  vld;
    kind_t kind;
    logic  first;
    logic  fin;
  } pipe_t;

  function automatic logic is_nonprint(input logic [7:0] b);
    logic esc;
    esc = (b == CH_NL) || (b == CH_CR) || (b == CH_TAB);
    return !esc && ((b < PRINT_LO) || (b > PRINT_HI));
  endfunction

endpackage

// ===== design/string_escape_hex_fallback_encoder_top.sv =====
// top level of the string escape encoder with hex fallback
// usage
//   request channel: raise start with byte_value, last_byte and no_byte;
//   a request is taken at a rising edge where start is high and busy low.
//   bytes are loaded into a 64-entry buffer ram, one per cycle while busy is low.
//   last_byte ends the string with that byte, no_byte ends it with none.
// results
//   each result group is on the result ports for one cycle with strobe
//   high; the receiver cannot stall, so results are never held back.
//   a string of n bytes gives n groups on consecutive cycles; strobe for
//   the first one rises once the ending request has passed the sequencer
//   state, then the ram read and pipeline slot, then the output register;
//   the single ram read port walking the buffer paces the groups. empty
//   and overflowed strings give one group, with no ram read, from the
//   pipeline slot through the output register. busy is high while the
//   buffer is walked after a string ends; then the next string may start
//   loading while the last group is still being shown.
// reset: rst clears the counter, flags and sequencer; buffer contents
//   stay undefined and are never read before being written
module string_escape_hex_fallback_encoder_top import ses_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] byte_value,
  input  logic       last_byte,
  input  logic       no_byte,
  output logic       strobe,
  output logic [7:0] char_a,
  output logic [7:0] char_b,
  output logic [7:0] char_c,
  output logic [7:0] char_d,
  output logic [7:0] char_e,
  output logic [2:0] char_count,
  output logic       binary_mode,
  output logic       too_long,
  output logic       last_group
);

  // buffer ram access
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;

  // read pipeline slot, aligned with rd_data
  pipe_t pipe;

  // counter, flags and sequencer
  ses_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .byte_value (byte_value),
    .last_byte  (last_byte),
    .no_byte    (no_byte),
    .busy       (busy),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .pipe       (pipe)
  );

  // string buffer
  ses_ram #(
    .DATA_W (8),
    .DEPTH  (MAX_LEN)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // group formatting and output register
  ses_fmt u_fmt (
    .clk         (clk),
    .rst         (rst),
    .pipe        (pipe),
    .rd_data     (rd_data),
    .strobe      (strobe),
    .char_a      (char_a),
    .char_b      (char_b),
    .char_c      (char_c),
    .char_d      (char_d),
    .char_e      (char_e),
    .char_count  (char_count),
    .binary_mode (binary_mode),
    .too_long    (too_long),
    .last_group  (last_group)
  );

endmodule

// ===== design/ses_ram.sv =====
// single-port-write, single-port-read buffer ram, registered read
module ses_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/ses_ctrl.sv =====
// load counter, flags and emission sequencer
module ses_ctrl import ses_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [7:0]        byte_value,
  input  logic              last_byte,
  input  logic              no_byte,
  output logic              busy,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [7:0]        wr_data,
  output logic              rd_en,
  output logic [ADDR_W-1:0] rd_addr,
  output pipe_t             pipe
);

  state_t           state, state_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic             saw_nonprint, saw_nonprint_next;
  logic             overflowed, overflowed_next;
  logic [CNT_W-1:0] emit_cnt, emit_cnt_next;
  logic             emit_bin, emit_bin_next;
  logic [CNT_W-1:0] rd_idx, rd_idx_next;
  pipe_t            pipe_next;

  logic             accept;
  logic             room;
  logic             ovf_now;
  logic             nonp_now;
  logic [CNT_W-1:0] cnt_now;
  logic             ending;
  logic             fin;

  assign busy    = (state == ST_EMIT);
  assign accept  = start && !busy;
  assign room    = (byte_count < CNT_W'(MAX_LEN));
  assign wr_en   = accept && !no_byte && room;
  assign wr_addr = byte_count[ADDR_W-1:0];
  assign wr_data = byte_value;
  assign rd_addr = rd_idx[ADDR_W-1:0];
  assign fin     = (rd_idx + CNT_W'(1)) == emit_cnt;

  always_comb begin
    ovf_now  = overflowed || (accept && !no_byte && !room);
    nonp_now = saw_nonprint || (wr_en && is_nonprint(byte_value));
    cnt_now  = wr_en ? byte_count + CNT_W'(1) : byte_count;
    ending   = accept && (no_byte || last_byte);
  end

  always_comb begin
    state_next        = state;
    byte_count_next   = byte_count;
    saw_nonprint_next = saw_nonprint;
    overflowed_next   = overflowed;
    emit_cnt_next     = emit_cnt;
    emit_bin_next     = emit_bin;
    rd_idx_next       = rd_idx;
    rd_en             = 1'b0;
    pipe_next         = '{vld: 1'b0, kind: KIND_ESC, first: 1'b0, fin: 1'b0};
    unique case (state)
      ST_LOAD: begin
        if (accept) begin
          byte_count_next   = cnt_now;
          saw_nonprint_next = nonp_now;
          overflowed_next   = ovf_now;
        end
        if (ending) begin
          byte_count_next   = '0;
          saw_nonprint_next = 1'b0;
          overflowed_next   = 1'b0;
          if (ovf_now) begin
            pipe_next = '{vld: 1'b1, kind: KIND_LONG, first: 1'b1, fin: 1'b1};
          end else if (cnt_now == '0) begin
            pipe_next = '{vld: 1'b1, kind: KIND_EMPTY, first: 1'b1, fin: 1'b1};
          end else begin
            emit_cnt_next = cnt_now;
            emit_bin_next = nonp_now;
            rd_idx_next   = '0;
            state_next    = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        rd_en       = 1'b1;
        pipe_next   = '{vld: 1'b1, kind: emit_bin ? KIND_HEX : KIND_ESC,
                        first: (rd_idx == '0), fin: fin};
        rd_idx_next = rd_idx + CNT_W'(1);
        if (fin) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      byte_count   <= '0;
      saw_nonprint <= 1'b0;
      overflowed   <= 1'b0;
      pipe         <= '{vld: 1'b0, kind: KIND_ESC, first: 1'b0, fin: 1'b0};
    end else begin
      state        <= state_next;
      byte_count   <= byte_count_next;
      saw_nonprint <= saw_nonprint_next;
      overflowed   <= overflowed_next;
      pipe         <= pipe_next;
    end
  end

  always_ff @(posedge clk) begin
    emit_cnt <= emit_cnt_next;
    emit_bin <= emit_bin_next;
    rd_idx   <= rd_idx_next;
  end

endmodule

// ===== design/ses_fmt.sv =====
// result formatter: escapes or hex groups, output register
module ses_fmt import ses_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  pipe_t      pipe,
  input  logic [7:0] rd_data,
  output logic       strobe,
  output logic [7:0] char_a,
  output logic [7:0] char_b,
  output logic [7:0] char_c,
  output logic [7:0] char_d,
  output logic [7:0] char_e,
  output logic [2:0] char_count,
  output logic       binary_mode,
  output logic       too_long,
  output logic       last_group
);

  logic [7:0] ca, cb, cc, cd, ce;
  logic [2:0] cnt;
  logic [7:0] hi, lo, sep;

  always_comb begin
    hi  = HEX_DIGITS[rd_data[7:4]];
    lo  = HEX_DIGITS[rd_data[3:0]];
    sep = pipe.fin ? CH_RPAREN : CH_SPACE;
    ca  = '0;
    cb  = '0;
    cc  = '0;
    cd  = '0;
    ce  = '0;
    cnt = 3'd0;
    unique case (pipe.kind)
      KIND_ESC: begin
        cnt = 3'd2;
        ca  = CH_QUOTE;
        priority if (rd_data == CH_NL) begin
          cb = CH_N;
        end else if (rd_data == CH_CR) begin
          cb = CH_R;
        end else if (rd_data == CH_TAB) begin
          cb = CH_T;
        end else if (rd_data == CH_QUOTE) begin
          cb = CH_QUOTE;
        end else begin
          ca  = rd_data;
          cnt = 3'd1;
        end
      end
      KIND_HEX: begin
        if (pipe.first) begin
          ca  = CH_QUOTE;
          cb  = CH_LPAREN;
          cc  = hi;
          cd  = lo;
          ce  = sep;
          cnt = 3'd5;
        end else begin
          ca  = hi;
          cb  = lo;
          cc  = sep;
          cnt = 3'd3;
        end
      end
      KIND_EMPTY: cnt = 3'd0;
      KIND_LONG:  cnt = 3'd0;
      default:    cnt = 3'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= pipe.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe.vld) begin
      char_a      <= ca;
      char_b      <= cb;
      char_c      <= cc;
      char_d      <= cd;
      char_e      <= ce;
      char_count  <= cnt;
      binary_mode <= (pipe.kind == KIND_HEX);
      too_long    <= (pipe.kind == KIND_LONG);
      last_group  <= pipe.fin;
    end
  end

endmodule

// ===== design/ses_checker.sv =====
// port-level checker for the string escape encoder, with its bind
`include "assert_macros.svh"

module ses_checker (
  input logic       clk,
  input logic       rst,
  input logic       strobe,
  input logic [2:0] char_count,
  input logic       binary_mode,
  input logic       too_long,
  input logic       last_group
);

  // overflow result is a lone empty final group
  `ASSERT_IMPL(a_long_alone, clk, rst, strobe && too_long,
    char_count == 3'd0 && last_group && !binary_mode)

  // hex groups carry three or five characters
  `ASSERT_IMPL(a_hex_count, clk, rst, strobe && binary_mode,
    char_count == 3'd3 || char_count == 3'd5)

  // escape groups carry at most two characters
  `ASSERT_IMPL(a_esc_count, clk, rst, strobe && !binary_mode,
    char_count <= 3'd2)

  // groups of a hex string come back to back, continuing with three characters
  `ASSERT_NEXT(a_hex_run, clk, rst, strobe && binary_mode && !last_group,
    strobe && binary_mode && char_count == 3'd3)

endmodule

bind string_escape_hex_fallback_encoder_top ses_checker u_ses_checker (
  .clk         (clk),
  .rst         (rst),
  .strobe      (strobe),
  .char_count  (char_count),
  .binary_mode (binary_mode),
  .too_long    (too_long),
  .last_group  (last_group)
);

// ===== bench/string_escape_hex_fallback_encoder_top_tb.sv =====
// self-checking testbench for the string escape encoder with hex fallback
module string_escape_hex_fallback_encoder_top_tb import ses_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  // hard stop, far above the slowest legal run (every string waits out its
  // full emission walk plus the longest sender gap on every request)
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_ITEMS  = 330;
  localparam int DRAIN_CYCLES  = 8;
  localparam int GAP_PERCENT   = 21;

  typedef logic [7:0] byte_q_t [$];

  // one encoded group as seen on the result ports, char_a in slot 0
  typedef struct packed {
    logic [4:0][7:0] ch;
    logic [2:0]      cnt;
    logic            bin;
    logic            tl;
    logic            fin;
  } enc_group_t;

  // tracks the string being loaded and the groups it must produce
  class escape_scoreboard;
    logic [7:0] held [MAX_LEN];
    int         fill = 0;
    bit         any_nonprint = 0;
    bit         spilled = 0;
    enc_group_t pending_groups [$];
    int         errors = 0;
    int         groups_checked = 0;
    int         strings_done = 0;
    int         esc_strings = 0;
    int         hex_strings = 0;
    int         empty_strings = 0;
    int         long_strings = 0;

    function logic [7:0] hex_char(logic [3:0] nib);
      // 8'h57 + 10 lands on lowercase a
      return (nib < 4'd10) ? 8'h30 + {4'h0, nib} : 8'h57 + {4'h0, nib};
    endfunction

    function void push_group(logic [4:0][7:0] ch, int n, bit bin, bit tl, bit fin);
      enc_group_t g;
      for (int k = 0; k < 5; k++)
        g.ch[k] = (k < n) ? ch[k] : 8'h00;
      g.cnt = n[2:0];
      g.bin = bin;
      g.tl  = tl;
      g.fin = fin;
      pending_groups.push_back(g);
    endfunction

    // called for every accepted request
    function void take_request(logic [7:0] b, logic lst, logic none);
      logic [4:0][7:0] ch;
      int              k;
      bit              fin;
      if (!none) begin
        if (fill < MAX_LEN) begin
          held[fill] = b;
          fill++;
          if (!(b == CH_NL || b == CH_CR || b == CH_TAB) && (b < PRINT_LO || b > PRINT_HI))
            any_nonprint = 1;
        end else begin
          spilled = 1;
        end
        if (!lst)
          return;
      end
      strings_done++;
      if (spilled) begin
        push_group('0, 0, 1'b0, 1'b1, 1'b1);
        long_strings++;
      end else if (fill == 0) begin
        push_group('0, 0, 1'b0, 1'b0, 1'b1);
        empty_strings++;
      end else if (any_nonprint) begin
        hex_strings++;
        for (int i = 0; i < fill; i++) begin
          ch  = '0;
          k   = 0;
          fin = (i == fill - 1);
          if (i == 0) begin
            ch[0] = CH_QUOTE;
            ch[1] = CH_LPAREN;
            k = 2;
          end
          ch[k]     = hex_char(held[i][7:4]);
          ch[k + 1] = hex_char(held[i][3:0]);
          ch[k + 2] = fin ? CH_RPAREN : CH_SPACE;
          push_group(ch, k + 3, 1'b1, 1'b0, fin);
        end
      end else begin
        esc_strings++;
        for (int i = 0; i < fill; i++) begin
          ch = '0;
          k  = 2;
          ch[0] = CH_QUOTE;
          case (held[i])
            CH_NL:    ch[1] = CH_N;
            CH_CR:    ch[1] = CH_R;
            CH_TAB:   ch[1] = CH_T;
            CH_QUOTE: ch[1] = CH_QUOTE;
            default: begin
              ch[0] = held[i];
              k = 1;
            end
          endcase
          push_group(ch, k, 1'b0, 1'b0, i == fill - 1);
        end
      end
      fill = 0;
      any_nonprint = 0;
      spilled = 0;
    endfunction

    function void check_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected 0x%02h, got 0x%02h", field, want, got);
        errors++;
      end
    endfunction

    // called for every strobed group
    function void check_group(enc_group_t got);
      enc_group_t want;
      string      char_names [5] = '{"char_a", "char_b", "char_c", "char_d", "char_e"};
      groups_checked++;
      if (pending_groups.size() == 0) begin
        $error("result group arrived with nothing expected");
        errors++;
        return;
      end
      want = pending_groups.pop_front();
      for (int k = 0; k < 5; k++)
        check_field(char_names[k], want.ch[k], got.ch[k]);
      check_field("char_count", 8'(want.cnt), 8'(got.cnt));
      check_field("binary_mode", 8'(want.bin), 8'(got.bin));
      check_field("too_long", 8'(want.tl), 8'(got.tl));
      check_field("last_group", 8'(want.fin), 8'(got.fin));
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [7:0] byte_value;
  logic       last_byte;
  logic       no_byte;
  logic       strobe;
  logic [7:0] char_a;
  logic [7:0] char_b;
  logic [7:0] char_c;
  logic [7:0] char_d;
  logic [7:0] char_e;
  logic [2:0] char_count;
  logic       binary_mode;
  logic       too_long;
  logic       last_group;

  escape_scoreboard sb;
  int cycles = 0;
  int items_sent = 0;
  bit steady = 0;   // set while the sender must not leave gaps

  string_escape_hex_fallback_encoder_top dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .byte_value  (byte_value),
    .last_byte   (last_byte),
    .no_byte     (no_byte),
    .strobe      (strobe),
    .char_a      (char_a),
    .char_b      (char_b),
    .char_c      (char_c),
    .char_d      (char_d),
    .char_e      (char_e),
    .char_count  (char_count),
    .binary_mode (binary_mode),
    .too_long    (too_long),
    .last_group  (last_group)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d groups still expected",
               cycles, sb.pending_groups.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: the receiver never stalls, so every strobe is a group;
  // sampled at the rising edge, before the block updates its outputs
  always @(posedge clk) begin
    enc_group_t got;
    if (!rst && strobe === 1'b1) begin
      got.ch  = {char_e, char_d, char_c, char_b, char_a};
      got.cnt = char_count;
      got.bin = binary_mode;
      got.tl  = too_long;
      got.fin = last_group;
      sb.check_group(got);
    end
  end

  // one request: idle cycles with noise on the bus, each drawn on its own,
  // then hold start until a rising edge sees busy low; returns at the
  // following falling edge with start still high, so back-to-back requests
  // never drop it
  task automatic drive_request(input logic [7:0] b, input logic lst, input logic none);
    if (!steady) begin
      while ($urandom_range(99) < GAP_PERCENT) begin
        start      = 1'b0;
        byte_value = 8'($urandom_range(255));
        last_byte  = 1'($urandom_range(1));
        no_byte    = 1'($urandom_range(1));
        @(negedge clk);
      end
    end
    start      = 1'b1;
    byte_value = b;
    last_byte  = lst;
    no_byte    = none;
    @(posedge clk);
    while (busy !== 1'b0)
      @(posedge clk);
    sb.take_request(b, lst, none);
    items_sent++;
    @(negedge clk);
  endtask

  // a whole string, closed either by last_byte on its final byte or by a
  // separate no_byte request (the only way to close an empty string)
  task automatic send_string(input byte_q_t s, input bit close_none);
    foreach (s[i])
      drive_request(s[i], !close_none && (i == s.size() - 1), 1'b0);
    if (close_none || s.size() == 0)
      drive_request(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
  endtask

  // sender holds off until every outstanding group has been seen
  task automatic wait_drained();
    start = 1'b0;
    while (sb.pending_groups.size() != 0)
      @(negedge clk);
  endtask

  // escape-heavy printable bytes, or anything at all
  function automatic logic [7:0] pick_byte(bit wild);
    int r;
    if (wild)
      return 8'($urandom_range(255));
    r = $urandom_range(99);
    if (r < 6)  return CH_NL;
    if (r < 10) return CH_CR;
    if (r < 14) return CH_TAB;
    if (r < 22) return CH_QUOTE;
    return 8'($urandom_range(32, 127));
  endfunction

  initial begin
    int      n_str;
    int      len;
    int      r;
    bit      wild;
    byte_q_t s;
    sb         = new();
    rst        = 1'b1;
    start      = 1'b0;
    byte_value = 8'h00;
    last_byte  = 1'b0;
    no_byte    = 1'b0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // directed strings
    // empty string, closer carries last_byte and a byte that must be ignored
    drive_request(8'hff, 1'b1, 1'b1);
    // single bytes at the printable boundaries and the byte extremes
    send_string('{8'h00}, 0);
    send_string('{8'hff}, 0);
    send_string('{PRINT_HI}, 0);
    send_string('{PRINT_LO}, 0);
    send_string('{8'h1f}, 0);
    send_string('{8'h80}, 0);
    // every escape plus a plain letter
    send_string('{CH_NL, CH_CR, CH_TAB, CH_QUOTE, 8'h41}, 0);
    // escapes do not count as nonprintable, but a high byte forces hex
    send_string('{CH_TAB, 8'h80}, 0);
    // bytes ended by no_byte
    send_string('{8'h61, 8'h62}, 1);
    // empty string with last_byte low
    drive_request(8'h00, 1'b0, 1'b1);

    // sender pause until the block has emitted everything
    wait_drained();

    // random strings, mostly short; the first two hit the full buffer and
    // the overflow, and a window of strings runs with no sender gaps
    n_str = 0;
    while (items_sent < RANDOM_ITEMS) begin
      steady = (n_str >= 10 && n_str < 20);
      if ($urandom_range(99) < 5)
        wait_drained();
      r = $urandom_range(99);
      if (n_str == 0)
        len = MAX_LEN;
      else if (n_str == 1)
        len = MAX_LEN + 1;
      else if (r < 80)
        len = $urandom_range(0, 8);
      else if (r < 90)
        len = $urandom_range(9, 30);
      else if (r < 95)
        len = $urandom_range(31, MAX_LEN);
      else
        len = $urandom_range(MAX_LEN + 1, MAX_LEN + 2);
      wild = ($urandom_range(99) < 30);
      s = {};
      for (int i = 0; i < len; i++)
        s.push_back(pick_byte(wild));
      send_string(s, $urandom_range(99) < 20);
      n_str++;
    end
    steady = 0;

    // drain, then idle for DRAIN_CYCLES so that any stray group would show
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (sb.pending_groups.size() != 0) begin
      $error("%0d expected groups never arrived", sb.pending_groups.size());
      sb.errors++;
    end
    $display("run covered %0d requests in %0d strings: %0d escaped, %0d hex,",
             items_sent, sb.strings_done, sb.esc_strings, sb.hex_strings);
    $display("%0d empty, %0d overflowed; %0d result groups checked, %0d mismatches",
             sb.empty_strings, sb.long_strings, sb.groups_checked, sb.errors);
    if (sb.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
